@@ rtl/bbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, register codes, the per-pixel flag bundle and the helper
// functions that clamp the configuration values.
// ----------------------------------------------------------------------------
package bbm_pkg;

  localparam int DefMaxSide   = 1024;
  localparam int DefMaxWindow = 15;
  localparam int DefPixelBits = 8;

  localparam int ImageSizeW  = 11;
  localparam int WindowSizeW = 4;
  localparam int CfgDataW    = 11;
  localparam int CfgIdxW     = 1;

  localparam int ResetImageSize  = 16;
  localparam int ResetWindowSize = 3;

  localparam logic [CfgIdxW-1:0] RegImageSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWindowSize = 1'b1;

  // Classification of one pixel, made by the front end.
  typedef struct packed {
    logic row_zero;   // first row of the frame
    logic col_zero;   // first column of the row
    logic row_old;    // line store holds the pixel k rows up
    logic col_old;    // recent sums hold the column sum k columns back
    logic emit;       // window is complete, a result follows
    logic frame_end;  // last pixel of the frame
  } bbm_flags_t;

  function automatic int clog2_min1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

  function automatic int side_eff(input int raw, input int maxv);
    int n;
    n = raw;
    if (n == 0) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // Window side: clamped, then forced odd by rounding down.
  function automatic int win_eff(input int raw, input int maxv);
    int k;
    k = raw;
    if (k == 0) k = 1;
    if (k > maxv) k = maxv;
    if ((k & 1) == 0) k = k - 1;
    if (k == 0) k = 1;
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur front end
// Holds the configuration, tracks the raster position and classifies each
// incoming pixel into addresses and flags for the back end.
// ----------------------------------------------------------------------------
module bbm_front #(
  parameter int MAX_SIDE   = bbm_pkg::DefMaxSide,
  parameter int MAX_WINDOW = bbm_pkg::DefMaxWindow,
  parameter int PIXEL_BITS = bbm_pkg::DefPixelBits,
  localparam int CW  = bbm_pkg::clog2_min1(MAX_SIDE),
  localparam int SW  = bbm_pkg::clog2_min1(MAX_WINDOW),
  localparam int LAW = bbm_pkg::clog2_min1(MAX_WINDOW * MAX_SIDE),
  localparam int AW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bbm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bbm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                           pixel_valid_i,
  output logic                                pixel_ready_o,
  input  wire logic [PIXEL_BITS-1:0]          pixel_i,
  output logic                                push_valid_o,
  input  wire logic                           push_ready_i,
  output logic [PIXEL_BITS-1:0]               push_pix_o,
  output logic [CW-1:0]                       push_col_o,
  output logic [LAW-1:0]                      push_laddr_o,
  output logic [SW-1:0]                       push_cslot_o,
  output logic [CW-1:0]                       push_ocol_o,
  output logic [CW-1:0]                       push_orow_o,
  output bbm_pkg::bbm_flags_t                 push_flags_o,
  output logic [AW-1:0]                       area_o
);
  import bbm_pkg::*;

  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int MX = (CW > KW) ? CW : KW;

  logic [CW-1:0] nm1_q, col_q, row_q;
  logic [KW-1:0] km1_q;
  logic [AW-1:0] area_q;
  logic [SW-1:0] cslot_q, rslot_q;

  logic [CW-1:0] nm1_new;
  logic [KW-1:0] k_new;
  logic [MX-1:0] col_x, row_x, km1_x, nm1_x;
  logic          accept, col_last, row_last, cslot_last, rslot_last;

  always_comb begin
    nm1_new = CW'(side_eff(int'(cfg_wdata_i[ImageSizeW-1:0]), MAX_SIDE) - 1);
    k_new   = KW'(win_eff(int'(cfg_wdata_i[WindowSizeW-1:0]), MAX_WINDOW));
  end

  assign col_x = MX'(col_q);
  assign row_x = MX'(row_q);
  assign km1_x = MX'(km1_q);
  assign nm1_x = MX'(nm1_q);

  assign col_last   = (col_q == nm1_q);
  assign row_last   = (row_q == nm1_q);
  assign cslot_last = (MX'(cslot_q) == km1_x);
  assign rslot_last = (MX'(rslot_q) == km1_x);

  assign pixel_ready_o = push_ready_i;
  assign push_valid_o  = pixel_valid_i;
  assign accept        = pixel_valid_i && push_ready_i;

  always_comb begin
    push_pix_o   = pixel_i;
    push_col_o   = col_q;
    push_laddr_o = LAW'(rslot_q) * LAW'(MAX_SIDE) + LAW'(col_q);
    push_cslot_o = cslot_q;
    // k is odd, so (k - 1) / 2 is the half width of the window.
    push_ocol_o  = col_q - CW'(km1_q >> 1);
    push_orow_o  = row_q - CW'(km1_q >> 1);
    push_flags_o.row_zero  = (row_q == '0);
    push_flags_o.col_zero  = (col_q == '0);
    push_flags_o.row_old   = (row_x > km1_x);
    push_flags_o.col_old   = (col_x > km1_x);
    push_flags_o.emit      = (km1_x <= nm1_x) && (row_x >= km1_x) && (col_x >= km1_x);
    push_flags_o.frame_end = col_last && row_last;
  end

  assign area_o = area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q   <= CW'(side_eff(ResetImageSize, MAX_SIDE) - 1);
      km1_q   <= KW'(win_eff(ResetWindowSize, MAX_WINDOW) - 1);
      area_q  <= AW'(win_eff(ResetWindowSize, MAX_WINDOW) *
                     win_eff(ResetWindowSize, MAX_WINDOW));
      col_q   <= '0;
      row_q   <= '0;
      cslot_q <= '0;
      rslot_q <= '0;
    end else if (cfg_we_i) begin
      // Any register write restarts the frame.
      unique case (cfg_idx_i)
        RegImageSize: begin
          nm1_q <= nm1_new;
        end
        RegWindowSize: begin
          km1_q  <= k_new - KW'(1);
          area_q <= AW'(k_new) * AW'(k_new);
        end
        default: begin
        end
      endcase
      col_q   <= '0;
      row_q   <= '0;
      cslot_q <= '0;
      rslot_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q   <= '0;
        cslot_q <= '0;
        if (row_last) begin
          row_q   <= '0;
          rslot_q <= '0;
        end else begin
          row_q   <= row_q + CW'(1);
          rslot_q <= rslot_last ? '0 : rslot_q + SW'(1);
        end
      end else begin
        col_q   <= col_q + CW'(1);
        cslot_q <= cslot_last ? '0 : cslot_q + SW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bbm_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur pixel queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bbm_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);
  import bbm_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PtrW'(1);
      if (pop)  rptr_q <= rptr_q + PtrW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bbm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur back end
// Reads the line store, column sum and recent column sum memories for one
// pixel, then updates them and the running window total.
// ----------------------------------------------------------------------------
module bbm_back #(
  parameter int MAX_SIDE   = bbm_pkg::DefMaxSide,
  parameter int MAX_WINDOW = bbm_pkg::DefMaxWindow,
  parameter int PIXEL_BITS = bbm_pkg::DefPixelBits,
  localparam int CW  = bbm_pkg::clog2_min1(MAX_SIDE),
  localparam int SW  = bbm_pkg::clog2_min1(MAX_WINDOW),
  localparam int LAW = bbm_pkg::clog2_min1(MAX_WINDOW * MAX_SIDE),
  localparam int WTW = $clog2(MAX_WINDOW * MAX_WINDOW * (2 ** PIXEL_BITS - 1) + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  desc_valid_i,
  output logic                       desc_ready_o,
  input  wire logic [PIXEL_BITS-1:0] desc_pix_i,
  input  wire logic [CW-1:0]         desc_col_i,
  input  wire logic [LAW-1:0]        desc_laddr_i,
  input  wire logic [SW-1:0]         desc_cslot_i,
  input  wire logic [CW-1:0]         desc_ocol_i,
  input  wire logic [CW-1:0]         desc_orow_i,
  input  wire bbm_pkg::bbm_flags_t   desc_flags_i,
  output logic                       div_valid_o,
  input  wire logic                  div_ready_i,
  output logic [WTW-1:0]             div_sum_o,
  output logic [CW-1:0]              div_col_o,
  output logic [CW-1:0]              div_row_o,
  output logic                       div_fend_o
);
  import bbm_pkg::*;

  localparam int CSW     = $clog2(MAX_WINDOW * (2 ** PIXEL_BITS - 1) + 1);
  localparam int LsDepth = MAX_WINDOW * MAX_SIDE;

  typedef enum logic {
    StIdle,
    StUpdate
  } state_e;

  state_e st_q;

  logic [PIXEL_BITS-1:0] ls_mem [LsDepth];
  logic [CSW-1:0]        cs_mem [MAX_SIDE];
  logic [CSW-1:0]        rc_mem [MAX_WINDOW];

  logic [PIXEL_BITS-1:0] pix_q, ls_rd_q;
  logic [CW-1:0]         col_q, ocol_q, orow_q;
  logic [LAW-1:0]        laddr_q;
  logic [SW-1:0]         cslot_q;
  bbm_flags_t            flags_q;
  logic [CSW-1:0]        cs_rd_q, rc_rd_q;
  logic [WTW-1:0]        wt_q;

  logic                  pop, adv;
  logic [CSW-1:0]        cs_new;
  logic [WTW-1:0]        wt_new;

  assign desc_ready_o = (st_q == StIdle);
  assign pop          = desc_valid_i && desc_ready_o;
  assign adv          = (st_q == StUpdate) && (!flags_q.emit || div_ready_i);

  // Vertical sum drops the pixel k rows up, horizontal sum drops the column
  // sum k columns back; both restart at the first row or column.
  always_comb begin
    if (flags_q.row_zero) begin
      cs_new = CSW'(pix_q);
    end else begin
      cs_new = cs_rd_q + CSW'(pix_q) - (flags_q.row_old ? CSW'(ls_rd_q) : '0);
    end
    if (flags_q.col_zero) begin
      wt_new = WTW'(cs_new);
    end else begin
      wt_new = wt_q + WTW'(cs_new) - (flags_q.col_old ? WTW'(rc_rd_q) : '0);
    end
  end

  assign div_valid_o = (st_q == StUpdate) && flags_q.emit;
  assign div_sum_o   = wt_new;
  assign div_col_o   = ocol_q;
  assign div_row_o   = orow_q;
  assign div_fend_o  = flags_q.frame_end;

  always_ff @(posedge clk_i) begin
    if (pop) ls_rd_q <= ls_mem[desc_laddr_i];
    if (adv) ls_mem[laddr_q] <= pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop) cs_rd_q <= cs_mem[desc_col_i];
    if (adv) cs_mem[col_q] <= cs_new;
  end

  always_ff @(posedge clk_i) begin
    if (pop) rc_rd_q <= rc_mem[desc_cslot_i];
    if (adv) rc_mem[cslot_q] <= cs_new;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pix_q   <= desc_pix_i;
      col_q   <= desc_col_i;
      laddr_q <= desc_laddr_i;
      cslot_q <= desc_cslot_i;
      ocol_q  <= desc_ocol_i;
      orow_q  <= desc_orow_i;
      flags_q <= desc_flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      wt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (pop) st_q <= StUpdate;
        end
        StUpdate: begin
          if (adv) begin
            wt_q <= wt_new;
            st_q <= StIdle;
          end
        end
        default: begin
          st_q <= StIdle;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (st_q == StUpdate))
    else $error("pixel taken from the queue without moving to the update step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StUpdate && !adv) |=> (st_q == StUpdate && $stable(laddr_q) &&
                                    $stable(wt_q) && $stable(flags_q)))
    else $error("stalled update lost its pixel or window total");

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && flags_q.col_zero) |=> (wt_q == WTW'($past(cs_new))))
    else $error("window total did not restart at the first column");

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (st_q == StIdle))
    else $error("pixel updated more than once");
`endif

endmodule
`default_nettype wire

@@ rtl/bbm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur mean divider
// Serial restoring divider producing floor((2*S + A) / (2*A)), one quotient
// bit per cycle, with an output register toward the result channel.
// ----------------------------------------------------------------------------
module bbm_div #(
  parameter int MAX_SIDE   = bbm_pkg::DefMaxSide,
  parameter int MAX_WINDOW = bbm_pkg::DefMaxWindow,
  parameter int PIXEL_BITS = bbm_pkg::DefPixelBits,
  localparam int CW  = bbm_pkg::clog2_min1(MAX_SIDE),
  localparam int AW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1),
  localparam int WTW = $clog2(MAX_WINDOW * MAX_WINDOW * (2 ** PIXEL_BITS - 1) + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [WTW-1:0]        sum_i,
  input  wire logic [AW-1:0]         area_i,
  input  wire logic [CW-1:0]         col_i,
  input  wire logic [CW-1:0]         row_i,
  input  wire logic                  fend_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0]      blurred_o,
  output logic [CW-1:0]              out_col_o,
  output logic [CW-1:0]              out_row_o,
  output logic                       frame_end_o
);
  import bbm_pkg::*;

  localparam int QW  = PIXEL_BITS;
  localparam int NW  = $clog2((2 ** (PIXEL_BITS + 1) - 1) * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DW  = AW + QW;
  localparam int RW  = (NW > DW) ? NW : DW;
  localparam int CNW = clog2_min1(QW);

  logic           busy_q, done_q, ov_q;
  logic [CNW-1:0] cnt_q;
  logic [RW-1:0]  rem_q, den_q;
  logic [QW-1:0]  quo_q;
  logic [CW-1:0]  col_q, row_q;
  logic           fend_q;

  logic [QW-1:0]  res_q;
  logic [CW-1:0]  ocol_q, orow_q;
  logic           ofend_q;

  logic           load, step, xfer, ge;
  logic [RW-1:0]  num, den0, rem_d;
  logic [QW:0]    qsh;

  assign in_ready_o = !busy_q;
  assign load       = in_valid_i && !busy_q;
  assign step       = busy_q && !done_q;
  assign xfer       = done_q && (!ov_q || out_ready_i);

  always_comb begin
    num   = RW'({sum_i, 1'b0}) + RW'(area_i);
    den0  = RW'({area_i, 1'b0}) << (QW - 1);
    ge    = (rem_q >= den_q);
    rem_d = ge ? rem_q - den_q : rem_q;
    qsh   = {quo_q, ge};
  end

  assign out_valid_o = ov_q;
  assign blurred_o   = res_q;
  assign out_col_o   = ocol_q;
  assign out_row_o   = orow_q;
  assign frame_end_o = ofend_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= num;
      den_q  <= den0;
      quo_q  <= '0;
      col_q  <= col_i;
      row_q  <= row_i;
      fend_q <= fend_i;
    end else if (step) begin
      rem_q <= rem_d;
      den_q <= den_q >> 1;
      quo_q <= qsh[QW-1:0];
    end
    if (xfer) begin
      res_q   <= quo_q;
      ocol_q  <= col_q;
      orow_q  <= row_q;
      ofend_q <= fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CNW'(QW - 1);
      end else if (step) begin
        if (cnt_q == '0) begin
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNW'(1);
        end
      end else if (xfer) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end
      if (xfer) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/box_blur_mean_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box blur mean filter
// Streams a square image in raster order and emits the rounded mean of every
// complete k by k window, tagged with the window center.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result is the k by k window mean rounded
// half up, with the center column and row and a flag on the last interior
// pixel of the frame. Border pixels give no result. A write to either register
// takes effect at once and restarts the frame. In the back end every pixel
// has two steps: it reads the line store, column-sum and recent-sum memories,
// then writes them back, and the back end takes no new pixel until both are
// done. A pixel that yields a result also needs the serial divider, which
// takes no new window total until it has passed the last one on to the
// result register. A two-entry queue sits between the front end and the back
// end, and a result register sits at the output, so a waiting result does
// not stop the input at once. The memories are not cleared after reset: every
// entry is written earlier in the same frame before it is read.
// ----------------------------------------------------------------------------
module box_blur_mean_filter #(
  parameter int MAX_SIDE   = bbm_pkg::DefMaxSide,
  parameter int MAX_WINDOW = bbm_pkg::DefMaxWindow,
  parameter int PIXEL_BITS = bbm_pkg::DefPixelBits,
  localparam int CW = bbm_pkg::clog2_min1(MAX_SIDE)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         pixel_valid_i,
  output logic                              pixel_ready_o,
  input  wire logic [PIXEL_BITS-1:0]        pixel_i,
  output logic                              result_valid_o,
  input  wire logic                         result_ready_i,
  output logic [PIXEL_BITS-1:0]             blurred_o,
  output logic [CW-1:0]                     out_col_o,
  output logic [CW-1:0]                     out_row_o,
  output logic                              frame_end_o
);
  import bbm_pkg::*;

  localparam int SW  = clog2_min1(MAX_WINDOW);
  localparam int LAW = clog2_min1(MAX_WINDOW * MAX_SIDE);
  localparam int AW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int WTW = $clog2(MAX_WINDOW * MAX_WINDOW * (2 ** PIXEL_BITS - 1) + 1);
  localparam int FW  = $bits(bbm_flags_t);
  localparam int QDW = PIXEL_BITS + CW + LAW + SW + CW + CW + FW;

  logic                  f_valid, f_ready;
  logic [PIXEL_BITS-1:0] f_pix;
  logic [CW-1:0]         f_col, f_ocol, f_orow;
  logic [LAW-1:0]        f_laddr;
  logic [SW-1:0]         f_cslot;
  bbm_flags_t            f_flags;
  logic [AW-1:0]         area;

  logic                  b_valid, b_ready;
  logic [QDW-1:0]        q_in, q_out;
  logic [PIXEL_BITS-1:0] b_pix;
  logic [CW-1:0]         b_col, b_ocol, b_orow;
  logic [LAW-1:0]        b_laddr;
  logic [SW-1:0]         b_cslot;
  bbm_flags_t            b_flags;

  logic                  d_valid, d_ready, d_fend;
  logic [WTW-1:0]        d_sum;
  logic [CW-1:0]         d_col, d_row;

  bbm_front #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .push_valid_o  (f_valid),
    .push_ready_i  (f_ready),
    .push_pix_o    (f_pix),
    .push_col_o    (f_col),
    .push_laddr_o  (f_laddr),
    .push_cslot_o  (f_cslot),
    .push_ocol_o   (f_ocol),
    .push_orow_o   (f_orow),
    .push_flags_o  (f_flags),
    .area_o        (area)
  );

  assign q_in = {f_pix, f_col, f_laddr, f_cslot, f_ocol, f_orow, f_flags};
  assign {b_pix, b_col, b_laddr, b_cslot, b_ocol, b_orow, b_flags} = q_out;

  bbm_fifo #(
    .WIDTH (QDW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (q_in),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (q_out)
  );

  bbm_back #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (b_valid),
    .desc_ready_o (b_ready),
    .desc_pix_i   (b_pix),
    .desc_col_i   (b_col),
    .desc_laddr_i (b_laddr),
    .desc_cslot_i (b_cslot),
    .desc_ocol_i  (b_ocol),
    .desc_orow_i  (b_orow),
    .desc_flags_i (b_flags),
    .div_valid_o  (d_valid),
    .div_ready_i  (d_ready),
    .div_sum_o    (d_sum),
    .div_col_o    (d_col),
    .div_row_o    (d_row),
    .div_fend_o   (d_fend)
  );

  bbm_div #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .sum_i       (d_sum),
    .area_i      (area),
    .col_i       (d_col),
    .row_i       (d_row),
    .fend_i      (d_fend),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .blurred_o   (blurred_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .frame_end_o (frame_end_o)
  );

endmodule
`default_nettype wire
